// ===== sv/hkrb_pkg.sv =====
// Shared types and constants for the HID keyboard report builder.
// Used by every module of the block; has no dependencies of its own.
package hkrb_pkg;

    // Function codes of an input word
    localparam logic [1:0] FUNC_PRESS   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [1:0] FUNC_LOAD    = 2'd3;

    // Key code ranges and map value fields
    localparam logic [7:0] RAW_BASE    = 8'd136;
    localparam logic [7:0] MOD_BASE    = 8'd128;
    localparam logic [7:0] SHIFT_FLAG  = 8'h80;
    localparam logic [7:0] LSHIFT_MASK = 8'h02;
    localparam logic [7:0] USAGE_MASK  = 8'h7F;

    // ASCII map geometry (fixed by the 7-bit index field)
    localparam int MAP_DEPTH = 128;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    // Slots shown on the report port
    localparam int REPORT_SLOTS = 6;

    // Operation carried from front to back
    typedef enum logic [1:0] {
        OP_PRESS,
        OP_RELEASE,
        OP_CLEAR,
        OP_LOAD
    } op_t;

    // Input word
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_code;
        logic [6:0] map_index;
        logic [7:0] map_value;
        logic       link_up;
    } req_t;

    // Result word
    typedef struct packed {
        logic       accepted;
        logic       report_valid;
        logic [7:0] modifier_bits;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } rsp_t;

    // Decoded command between front and back
    typedef struct packed {
        op_t        op;
        logic       reject;
        logic [7:0] mod_mask;
        logic [7:0] usage;
        logic       link_up;
    } cmd_t;

    // Queue status toward its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/hkrb_front.sv =====
// Front end: accepts input words, owns the ASCII usage map, decodes key codes.
// Depends on hkrb_pkg; feeds hkrb_cmd_queue.
module hkrb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  hkrb_pkg::req_t  req,
    output logic            push,
    output hkrb_pkg::cmd_t  push_cmd,
    input  hkrb_pkg::q_status_t q_status
);

    typedef enum logic {
        F_IDLE,
        F_PUSH
    } fstate_t;

    fstate_t        state_reg, state_next;
    hkrb_pkg::req_t item_reg, item_next;
    logic [7:0]     map_rd_reg;
    logic [7:0]     map_mem [hkrb_pkg::MAP_DEPTH];
    logic           take;
    logic           map_wr;

    assign req_stall = (state_reg != F_IDLE);
    assign take      = req_valid && (state_reg == F_IDLE);
    assign map_wr    = take && (req.func == hkrb_pkg::FUNC_LOAD);

    // Map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (map_wr)
        begin
            map_mem[req.map_index] <= req.map_value;
        end
        if (take)
        begin
            map_rd_reg <= map_mem[req.key_code[hkrb_pkg::MAP_AW-1:0]];
        end
    end

    // Decode the held word into a command
    always_comb
    begin
        push_cmd          = '0;
        push_cmd.link_up  = item_reg.link_up;
        case (item_reg.func)
            hkrb_pkg::FUNC_PRESS:   push_cmd.op = hkrb_pkg::OP_PRESS;
            hkrb_pkg::FUNC_RELEASE: push_cmd.op = hkrb_pkg::OP_RELEASE;
            hkrb_pkg::FUNC_CLEAR:   push_cmd.op = hkrb_pkg::OP_CLEAR;
            default:                push_cmd.op = hkrb_pkg::OP_LOAD;
        endcase
        if (item_reg.key_code >= hkrb_pkg::RAW_BASE)
        begin
            push_cmd.usage = item_reg.key_code - hkrb_pkg::RAW_BASE;
        end
        else if (item_reg.key_code >= hkrb_pkg::MOD_BASE)
        begin
            push_cmd.mod_mask = 8'd1 << item_reg.key_code[2:0];
        end
        else if (map_rd_reg == 8'd0)
        begin
            push_cmd.reject = 1'b1;
        end
        else
        begin
            if ((map_rd_reg & hkrb_pkg::SHIFT_FLAG) != 8'd0)
            begin
                push_cmd.mod_mask = hkrb_pkg::LSHIFT_MASK;
            end
            push_cmd.usage = map_rd_reg & hkrb_pkg::USAGE_MASK;
        end
    end

    assign push = (state_reg == F_PUSH) && !q_status.full;

    // Control sequencing
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    item_next  = req;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload holding register, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== sv/hkrb_cmd_queue.sv =====
// Two-entry command queue between the front end and the report engine.
// Depends on hkrb_pkg.
module hkrb_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hkrb_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output hkrb_pkg::cmd_t  pop_cmd,
    output hkrb_pkg::q_status_t status
);

    hkrb_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/hkrb_engine.sv =====
// Report engine: applies commands to the held keys and modifiers, drives results.
// Depends on hkrb_pkg; fed by hkrb_cmd_queue.
module hkrb_engine #(
    parameter int KEY_SLOTS = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  hkrb_pkg::cmd_t  cmd,
    input  hkrb_pkg::q_status_t q_status,
    output logic            pop,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output hkrb_pkg::rsp_t  rsp
);

    logic [7:0]     held_reg  [KEY_SLOTS];
    logic [7:0]     held_next [KEY_SLOTS];
    logic [7:0]     mods_reg, mods_next;
    logic           rsp_valid_reg, rsp_valid_next;
    hkrb_pkg::rsp_t rsp_reg, rsp_next;
    logic [7:0]     slot_view [hkrb_pkg::REPORT_SLOTS];
    logic           ok;
    logic           present;
    logic           found;

    assign pop       = !q_status.empty && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Apply one command
    always_comb
    begin
        held_next = held_reg;
        mods_next = mods_reg;
        ok        = 1'b0;
        present   = 1'b0;
        found     = 1'b0;
        case (cmd.op)
            hkrb_pkg::OP_PRESS:
            begin
                if (!cmd.reject)
                begin
                    mods_next = mods_reg | cmd.mod_mask;
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (held_reg[i] == cmd.usage)
                        begin
                            present = 1'b1;
                        end
                    end
                    // first empty slot takes a new usage
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if (!present && !found && (held_reg[i] == 8'd0))
                        begin
                            held_next[i] = cmd.usage;
                            found        = 1'b1;
                        end
                    end
                    ok = present || found;
                end
            end
            hkrb_pkg::OP_RELEASE:
            begin
                if (!cmd.reject)
                begin
                    mods_next = mods_reg & ~cmd.mod_mask;
                    for (int i = 0; i < KEY_SLOTS; i++)
                    begin
                        if ((cmd.usage != 8'd0) && (held_reg[i] == cmd.usage))
                        begin
                            held_next[i] = 8'd0;
                        end
                    end
                    ok = 1'b1;
                end
            end
            hkrb_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < KEY_SLOTS; i++)
                begin
                    held_next[i] = 8'd0;
                end
                mods_next = 8'd0;
                ok        = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Slots past KEY_SLOTS read as empty
    for (genvar j = 0; j < hkrb_pkg::REPORT_SLOTS; j++)
    begin : g_view
        if (j < KEY_SLOTS)
        begin : g_on
            assign slot_view[j] = held_next[j];
        end
        else
        begin : g_off
            assign slot_view[j] = 8'd0;
        end
    end

    // Result word and output register
    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_valid_next         = rsp_valid_reg;
        if (pop)
        begin
            rsp_next.accepted      = ok;
            rsp_next.report_valid  = ok && cmd.link_up;
            rsp_next.modifier_bits = mods_next;
            rsp_next.slot_zero     = slot_view[0];
            rsp_next.slot_one      = slot_view[1];
            rsp_next.slot_two      = slot_view[2];
            rsp_next.slot_three    = slot_view[3];
            rsp_next.slot_four     = slot_view[4];
            rsp_next.slot_five     = slot_view[5];
            rsp_valid_next         = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                held_reg[i] <= 8'd0;
            end
            mods_reg      <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_reg <= held_next;
                mods_reg <= mods_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// ===== sv/hid_keyboard_report_builder_core.sv =====
// HID boot keyboard report builder (six-key report), top level.
// Depends on hkrb_pkg, hkrb_front, hkrb_cmd_queue and hkrb_engine.
//
// Usage:
//   The req channel takes one word per key event: press, release,
//   release all, or load of one ASCII map entry. A word is taken at a
//   clock edge with req_valid high and req_stall low. Every word gives
//   exactly one result word on the rsp channel, in order: success flag,
//   report-sent flag (success while link_up was high) and the modifier
//   byte and six key slots after the event.
//   rsp_valid rises once the word has passed the front-end holding
//   register, the command queue and the engine's output register.
//   The front end takes no new word until the last one is pushed; it holds
//   req_stall while it reads the map, decodes the key and waits for the queue.
//   A two-entry command queue and one output register sit behind the
//   front end, so a stalled receiver lets at most four words be in flight
//   (one on the output, two queued, one in the front end) before req_stall
//   stays high.
//   Reset clears held keys, modifiers and all handshake state at once.
//   The ASCII map is not cleared; load every entry that will be used.
//   While rsp_stall is high the result word holds steady.
module hid_keyboard_report_builder_core #(
    parameter int KEY_SLOTS = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  hkrb_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output hkrb_pkg::rsp_t rsp
);

    logic                push;
    logic                pop;
    hkrb_pkg::cmd_t      push_cmd;
    hkrb_pkg::cmd_t      pop_cmd;
    hkrb_pkg::q_status_t q_status;

    // Accept and decode
    hkrb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_status  (q_status)
    );

    // Decoupling queue
    hkrb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    // Report state and result output
    hkrb_engine #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== sv/hkrb_checker.sv =====
// Port-level checks for the HID keyboard report builder, bound to the top level.
// Depends on hkrb_pkg and hid_keyboard_report_builder_core.
module hkrb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input hkrb_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input hkrb_pkg::rsp_t rsp
);

    // A stalled result word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("rsp_valid dropped while stalled");

    // A stalled result word keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("rsp changed while stalled");

    // A report is only sent for a successful event
    a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.report_valid |-> rsp.accepted)
        else $error("report sent for a rejected word");

    // Front end is busy for the cycle after taking a word
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("front end took words on consecutive cycles");

    // No result word is offered just as reset is released
    a_no_early_rsp: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result word right after reset");

endmodule

bind hid_keyboard_report_builder_core hkrb_checker u_hkrb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
